// ===== rtl/core/smmt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smmt_pkg
// Shared types, codes and reset values for the min/max scope column block.
// ----------------------------------------------------------------------------
package smmt_pkg;

    localparam int BUFFER_DEPTH_DEF = 2048;
    localparam int SAMPLE_BITS_DEF  = 16;

    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int ZOOM_W   = 16;
    localparam int HEIGHT_W = 13;
    localparam int WIDTH_W  = 12;
    localparam int SPP_W    = 11;
    localparam int INDEX_W  = 11;
    localparam int OPB_W    = 17;

    // commands
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_FRAME  = 2'd1;
    localparam logic [1:0] CMD_COLUMN = 2'd2;

    // trigger modes
    localparam logic [1:0] TRIG_OFF     = 2'd0;
    localparam logic [1:0] TRIG_RISING  = 2'd1;
    localparam logic [1:0] TRIG_FALLING = 2'd2;

    // result kinds
    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_COLUMN = 1'b1;

    // fill side codes
    localparam logic [1:0] FILL_NONE   = 2'd0;
    localparam logic [1:0] FILL_TOP    = 2'd1;
    localparam logic [1:0] FILL_BOTTOM = 2'd2;

    // register indexes
    localparam logic [2:0] REG_SPP    = 3'd0;
    localparam logic [2:0] REG_TRIG   = 3'd1;
    localparam logic [2:0] REG_ZOOM   = 3'd2;
    localparam logic [2:0] REG_WIDTH  = 3'd3;
    localparam logic [2:0] REG_HEIGHT = 3'd4;

    // register reset values
    localparam logic [SPP_W-1:0]    SPP_RST    = 11'd2;
    localparam logic [1:0]          TRIG_RST   = TRIG_RISING;
    localparam logic [ZOOM_W-1:0]   ZOOM_RST   = 16'd256;
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd512;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd512;

    typedef struct packed {
        logic [SPP_W-1:0]    samples_per_pixel;
        logic [1:0]          trigger_mode;
        logic [ZOOM_W-1:0]   vertical_zoom;
        logic [WIDTH_W-1:0]  display_width;
        logic [HEIGHT_W-1:0] display_height;
    } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/smmt_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smmt_if
// Valid/ready channels for input commands and column results.
// ----------------------------------------------------------------------------
interface smmt_in_if #(
    parameter int SAMPLE_BITS = smmt_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic signed [SAMPLE_BITS-1:0] sample_value;

    modport source (output valid, output command, output sample_value, input ready);
    modport sink   (input valid, input command, input sample_value, output ready);
endinterface

interface smmt_out_if;
    logic                                valid;
    logic                                ready;
    logic                                result_kind;
    logic                                trigger_found;
    logic [smmt_pkg::INDEX_W-1:0]        start_index;
    logic [smmt_pkg::INDEX_W-1:0]        column_x;
    logic [smmt_pkg::HEIGHT_W-1:0]       top_row;
    logic [smmt_pkg::HEIGHT_W-1:0]       bottom_row;
    logic [1:0]                          fill_side;
    logic                                last_column;

    modport source (output valid, output result_kind, output trigger_found,
                    output start_index, output column_x, output top_row,
                    output bottom_row, output fill_side, output last_column,
                    input ready);
    modport sink   (input valid, input result_kind, input trigger_found,
                    input start_index, input column_x, input top_row,
                    input bottom_row, input fill_side, input last_column,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/core/scope_minmax_trigger_columns.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scope_minmax_trigger_columns
// Min/max decimating scope column generator with an edge trigger search.
//
// channel     dir  beat contents
// sample_in   in   command, sample_value
// column_out  out  result_kind, trigger_found, start_index, column_x,
//                  top_row, bottom_row, fill_side, last_column
// apb         in   psel/penable/pwrite/paddr/pwdata, prdata, pready
//
// a sample is folded into the running min/max as it is accepted; a column
// takes four passes through the shared multiplier (ZMAX, DMAX, ZMIN, DMIN)
// and then FIN; a frame start goes straight to REPORT with the trigger off,
// else the search steps back one ring position a cycle through the memory
// read ports; after reset a clearing pass zeroes the ring memory
// a result waits in the output register while column_out.ready is low; the
// sequencer holds its last step until that register frees up
// ----------------------------------------------------------------------------
module scope_minmax_trigger_columns #(
    parameter int BUFFER_DEPTH = smmt_pkg::BUFFER_DEPTH_DEF,
    parameter int SAMPLE_BITS  = smmt_pkg::SAMPLE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    smmt_in_if.sink                      sample_in,
    smmt_out_if.source                   column_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [smmt_pkg::PADDR_W-1:0] paddr,
    input  logic [smmt_pkg::PDATA_W-1:0] pwdata,
    output logic [smmt_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import smmt_pkg::*;

    localparam int AW  = $clog2(BUFFER_DEPTH);
    localparam int PW  = $clog2(BUFFER_DEPTH + 1);
    localparam int DW  = SAMPLE_BITS + 17;
    localparam int PRW = DW + OPB_W;
    localparam int QW  = PRW - (8 + SAMPLE_BITS);

    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [DW-1:0] HALF = DW'(64'd1 << (7 + SAMPLE_BITS));

    typedef enum logic [8:0] {
        ST_CLEAR  = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_SEARCH = 9'b000000100,
        ST_ZMAX   = 9'b000001000,
        ST_DMAX   = 9'b000010000,
        ST_ZMIN   = 9'b000100000,
        ST_DMIN   = 9'b001000000,
        ST_FIN    = 9'b010000000,
        ST_REPORT = 9'b100000000
    } state_t;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (32'(p) == BUFFER_DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        ptr_dec = (p == '0) ? AW'(BUFFER_DEPTH - 1) : p - 1'b1;
    endfunction

    cfg_t cfg;

    state_t state_reg, state_next;

    logic signed [SAMPLE_BITS-1:0] run_min_reg, run_min_next;
    logic signed [SAMPLE_BITS-1:0] run_max_reg, run_max_next;
    logic [SPP_W-1:0]              left_reg, left_next;
    logic [AW-1:0]                 wp_reg, wp_next;
    logic [AW-1:0]                 rp_reg, rp_next;
    logic [WIDTH_W-1:0]            cdone_reg, cdone_next;
    logic [AW-1:0]                 clr_reg, clr_next;
    logic [AW-1:0]                 pos_reg, pos_next;
    logic [PW-1:0]                 issue_reg, issue_next;
    logic                          chk_valid_reg, chk_valid_next;
    logic [AW-1:0]                 chk_pos_reg, chk_pos_next;
    logic [AW-1:0]                 start_reg, start_next;
    logic                          found_reg, found_next;
    logic [SAMPLE_BITS-1:0]        vmin_reg, vmin_next;
    logic [HEIGHT_W-1:0]           top_reg, top_next;
    logic                          top_up_reg, top_up_next;
    logic [INDEX_W-1:0]            colx_reg, colx_next;
    logic                          last_reg, last_next;

    logic                          out_valid_reg, out_valid_next;
    logic                          o_kind_reg, o_kind_next;
    logic                          o_found_reg, o_found_next;
    logic [INDEX_W-1:0]            o_start_reg, o_start_next;
    logic [INDEX_W-1:0]            o_colx_reg, o_colx_next;
    logic [HEIGHT_W-1:0]           o_top_reg, o_top_next;
    logic [HEIGHT_W-1:0]           o_bot_reg, o_bot_next;
    logic [1:0]                    o_fill_reg, o_fill_next;
    logic                          o_last_reg, o_last_next;

    logic                          in_beat;
    logic                          out_free;
    logic signed [SAMPLE_BITS-1:0] s_val;
    logic signed [SAMPLE_BITS-1:0] new_min;
    logic signed [SAMPLE_BITS-1:0] new_max;
    logic [SPP_W-1:0]              spp_eff;
    logic [WIDTH_W-1:0]            frame_w;
    logic [PW:0]                   wp_x;
    logic [PW:0]                   w_x;
    logic [AW-1:0]                 start_pos;

    logic                          st_we;
    logic [AW-1:0]                 st_waddr;
    logic [SAMPLE_BITS-1:0]        st_wmin;
    logic [SAMPLE_BITS-1:0]        st_wmax;
    logic [AW-1:0]                 st_rmin_addr;
    logic [AW-1:0]                 st_rmax_addr;
    logic [SAMPLE_BITS-1:0]        st_rmin;
    logic [SAMPLE_BITS-1:0]        st_rmax;

    logic                          mul_en;
    logic signed [DW-1:0]          mul_a;
    logic signed [OPB_W-1:0]       mul_b;
    logic signed [PRW-1:0]         mul_p;

    logic signed [PRW-1:0]         shifted;
    logic [QW-1:0]                 q_val;
    logic [HEIGHT_W-1:0]           row_calc;
    logic                          up_calc;
    logic signed [PRW-1:0]         half_h;
    logic                          hit;
    logic signed [OPB_W-1:0]       zoom_op;
    logic signed [OPB_W-1:0]       height_op;

    smmt_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    smmt_store #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_store (
        .clk         (clk),
        .wr_en       (st_we),
        .wr_addr     (st_waddr),
        .wr_min      (st_wmin),
        .wr_max      (st_wmax),
        .rd_min_addr (st_rmin_addr),
        .rd_max_addr (st_rmax_addr),
        .rd_min      (st_rmin),
        .rd_max      (st_rmax)
    );

    smmt_mult #(
        .A_W (DW),
        .B_W (OPB_W)
    ) u_mult (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign sample_in.ready = (state_reg == ST_IDLE);
    assign in_beat         = sample_in.valid && sample_in.ready;
    assign out_free        = !out_valid_reg || column_out.ready;

    assign column_out.valid         = out_valid_reg;
    assign column_out.result_kind   = o_kind_reg;
    assign column_out.trigger_found = o_found_reg;
    assign column_out.start_index   = o_start_reg;
    assign column_out.column_x      = o_colx_reg;
    assign column_out.top_row       = o_top_reg;
    assign column_out.bottom_row    = o_bot_reg;
    assign column_out.fill_side     = o_fill_reg;
    assign column_out.last_column   = o_last_reg;

    // sample fold
    assign s_val   = sample_in.sample_value;
    assign new_min = (s_val < run_min_reg) ? s_val : run_min_reg;
    assign new_max = (s_val > run_max_reg) ? s_val : run_max_reg;
    assign spp_eff = (cfg.samples_per_pixel == '0) ? SPP_W'(1) : cfg.samples_per_pixel;

    // frame start point
    assign frame_w   = (32'(cfg.display_width) > BUFFER_DEPTH) ?
                       WIDTH_W'(BUFFER_DEPTH) : cfg.display_width;
    assign wp_x      = (PW+1)'(wp_reg);
    assign w_x       = (PW+1)'(frame_w);
    assign start_pos = (wp_x >= w_x) ? AW'(wp_x - w_x)
                                     : AW'(wp_x + (PW+1)'(BUFFER_DEPTH) - w_x);

    // trigger crossing
    always_comb
    begin
        if (cfg.trigger_mode == TRIG_RISING)
        begin
            hit = ($signed(st_rmin) <= 0) && ($signed(st_rmax) > 0);
        end
        else
        begin
            hit = ($signed(st_rmin) > 0) && ($signed(st_rmax) <= 0);
        end
    end

    // row mapping from the product register
    assign zoom_op   = $signed({1'b0, cfg.vertical_zoom});
    assign height_op = $signed(OPB_W'(cfg.display_height));
    assign shifted   = mul_p >>> (8 + SAMPLE_BITS);
    assign q_val     = shifted[QW-1:0];
    assign half_h    = $signed(PRW'(cfg.display_height) << (7 + SAMPLE_BITS));
    assign up_calc   = mul_p < half_h;

    always_comb
    begin
        if (mul_p[PRW-1])
        begin
            row_calc = '0;
        end
        else if (q_val > QW'(cfg.display_height))
        begin
            row_calc = cfg.display_height;
        end
        else
        begin
            row_calc = q_val[HEIGHT_W-1:0];
        end
    end

    // read address select
    always_comb
    begin
        if (state_reg == ST_SEARCH)
        begin
            st_rmax_addr = pos_reg;
            st_rmin_addr = ptr_dec(pos_reg);
        end
        else
        begin
            st_rmax_addr = ptr_inc(rp_reg);
            st_rmin_addr = ptr_inc(rp_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        run_min_next   = run_min_reg;
        run_max_next   = run_max_reg;
        left_next      = left_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        cdone_next     = cdone_reg;
        clr_next       = clr_reg;
        pos_next       = pos_reg;
        issue_next     = issue_reg;
        chk_valid_next = chk_valid_reg;
        chk_pos_next   = chk_pos_reg;
        start_next     = start_reg;
        found_next     = found_reg;
        vmin_next      = vmin_reg;
        top_next       = top_reg;
        top_up_next    = top_up_reg;
        colx_next      = colx_reg;
        last_next      = last_reg;

        out_valid_next = out_valid_reg && !column_out.ready;
        o_kind_next    = o_kind_reg;
        o_found_next   = o_found_reg;
        o_start_next   = o_start_reg;
        o_colx_next    = o_colx_reg;
        o_top_next     = o_top_reg;
        o_bot_next     = o_bot_reg;
        o_fill_next    = o_fill_reg;
        o_last_next    = o_last_reg;

        st_we    = 1'b0;
        st_waddr = wp_reg;
        st_wmin  = new_min;
        st_wmax  = new_max;

        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                st_we    = 1'b1;
                st_waddr = clr_reg;
                st_wmin  = '0;
                st_wmax  = '0;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == BUFFER_DEPTH - 1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_beat)
                begin
                    case (sample_in.command)
                        CMD_SAMPLE:
                        begin
                            if (left_reg <= SPP_W'(1))
                            begin
                                st_we        = 1'b1;
                                run_min_next = SMAX;
                                run_max_next = SMIN;
                                wp_next      = ptr_inc(wp_reg);
                                left_next    = spp_eff;
                            end
                            else
                            begin
                                run_min_next = new_min;
                                run_max_next = new_max;
                                left_next    = left_reg - 1'b1;
                            end
                        end

                        CMD_FRAME:
                        begin
                            pos_next       = start_pos;
                            start_next     = start_pos;
                            found_next     = 1'b0;
                            issue_next     = '0;
                            chk_valid_next = 1'b0;
                            if (cfg.trigger_mode == TRIG_OFF)
                            begin
                                state_next = ST_REPORT;
                            end
                            else
                            begin
                                state_next = ST_SEARCH;
                            end
                        end

                        CMD_COLUMN:
                        begin
                            if (cdone_reg < frame_w)
                            begin
                                rp_next    = ptr_inc(rp_reg);
                                cdone_next = cdone_reg + 1'b1;
                                colx_next  = cdone_reg[INDEX_W-1:0];
                                last_next  = ((13'(cdone_reg) + 13'd1) == 13'(frame_w));
                                state_next = ST_ZMAX;
                            end
                        end

                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SEARCH:
            begin
                chk_valid_next = 1'b0;
                if (chk_valid_reg && hit)
                begin
                    start_next = chk_pos_reg;
                    found_next = 1'b1;
                    state_next = ST_REPORT;
                end
                else if (32'(issue_reg) == BUFFER_DEPTH)
                begin
                    if (!chk_valid_reg)
                    begin
                        state_next = ST_REPORT;
                    end
                end
                else
                begin
                    chk_valid_next = 1'b1;
                    chk_pos_next   = pos_reg;
                    pos_next       = ptr_dec(pos_reg);
                    issue_next     = issue_reg + 1'b1;
                end
            end

            ST_ZMAX:
            begin
                mul_en     = 1'b1;
                mul_a      = DW'($signed(st_rmax));
                mul_b      = zoom_op;
                vmin_next  = st_rmin;
                state_next = ST_DMAX;
            end

            ST_DMAX:
            begin
                mul_en     = 1'b1;
                mul_a      = HALF - DW'(mul_p);
                mul_b      = height_op;
                state_next = ST_ZMIN;
            end

            ST_ZMIN:
            begin
                top_next    = row_calc;
                top_up_next = up_calc;
                mul_en      = 1'b1;
                mul_a       = DW'($signed(vmin_reg));
                mul_b       = zoom_op;
                state_next  = ST_DMIN;
            end

            ST_DMIN:
            begin
                mul_en     = 1'b1;
                mul_a      = HALF - DW'(mul_p);
                mul_b      = height_op;
                state_next = ST_FIN;
            end

            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_kind_next    = KIND_COLUMN;
                    o_found_next   = 1'b0;
                    o_start_next   = '0;
                    o_colx_next    = colx_reg;
                    o_top_next     = top_reg;
                    o_bot_next     = row_calc;
                    o_last_next    = last_reg;
                    if (top_up_reg && up_calc)
                    begin
                        o_fill_next = FILL_TOP;
                    end
                    else if (!top_up_reg && !up_calc)
                    begin
                        o_fill_next = FILL_BOTTOM;
                    end
                    else
                    begin
                        o_fill_next = FILL_NONE;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_REPORT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_kind_next    = KIND_FRAME;
                    o_found_next   = found_reg;
                    o_start_next   = INDEX_W'(start_reg);
                    o_colx_next    = '0;
                    o_top_next     = '0;
                    o_bot_next     = '0;
                    o_fill_next    = FILL_NONE;
                    o_last_next    = 1'b0;
                    rp_next        = start_reg;
                    cdone_next     = '0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            run_min_reg   <= SMAX;
            run_max_reg   <= SMIN;
            left_reg      <= SPP_RST;
            wp_reg        <= '0;
            rp_reg        <= '0;
            cdone_reg     <= WIDTH_RST;
            clr_reg       <= '0;
            issue_reg     <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_min_reg   <= run_min_next;
            run_max_reg   <= run_max_next;
            left_reg      <= left_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            cdone_reg     <= cdone_next;
            clr_reg       <= clr_next;
            issue_reg     <= issue_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        chk_pos_reg <= chk_pos_next;
        start_reg   <= start_next;
        found_reg   <= found_next;
        vmin_reg    <= vmin_next;
        top_reg     <= top_next;
        top_up_reg  <= top_up_next;
        colx_reg    <= colx_next;
        last_reg    <= last_next;
        o_kind_reg  <= o_kind_next;
        o_found_reg <= o_found_next;
        o_start_reg <= o_start_next;
        o_colx_reg  <= o_colx_next;
        o_top_reg   <= o_top_next;
        o_bot_reg   <= o_bot_next;
        o_fill_reg  <= o_fill_next;
        o_last_reg  <= o_last_next;
    end

    a_clear_quiet : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!column_out.valid && !sample_in.ready))
        else $error("activity during memory clear");

    a_frame_path : assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && sample_in.command == CMD_FRAME)
        |=> (state_reg == ST_SEARCH || state_reg == ST_REPORT))
        else $error("frame start did not enter search or report");

    a_column_fields : assert property (@(posedge clk) disable iff (!rst_n)
        (column_out.valid && column_out.result_kind == KIND_COLUMN)
        |-> (!column_out.trigger_found && column_out.start_index == '0))
        else $error("column result carries frame fields");

    a_mult_order : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> ($past(state_reg) == ST_DMIN || $past(state_reg) == ST_FIN))
        else $error("column finish out of multiplier order");

endmodule
`default_nettype wire

// ===== rtl/core/smmt_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smmt_cfg_regs
// APB-style configuration registers with read back.
// ----------------------------------------------------------------------------
module smmt_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [smmt_pkg::PADDR_W-1:0]   paddr,
    input  logic [smmt_pkg::PDATA_W-1:0]   pwdata,
    output logic [smmt_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output smmt_pkg::cfg_t                 cfg
);
    import smmt_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_beat;

    assign reg_idx = paddr[4:2];
    assign wr_beat = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_beat)
        begin
            case (reg_idx)
                REG_SPP:    cfg_next.samples_per_pixel = pwdata[SPP_W-1:0];
                REG_TRIG:   cfg_next.trigger_mode      = pwdata[1:0];
                REG_ZOOM:   cfg_next.vertical_zoom     = pwdata[ZOOM_W-1:0];
                REG_WIDTH:  cfg_next.display_width     = pwdata[WIDTH_W-1:0];
                REG_HEIGHT: cfg_next.display_height    = pwdata[HEIGHT_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SPP:    prdata = PDATA_W'(cfg_reg.samples_per_pixel);
            REG_TRIG:   prdata = PDATA_W'(cfg_reg.trigger_mode);
            REG_ZOOM:   prdata = PDATA_W'(cfg_reg.vertical_zoom);
            REG_WIDTH:  prdata = PDATA_W'(cfg_reg.display_width);
            REG_HEIGHT: prdata = PDATA_W'(cfg_reg.display_height);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.samples_per_pixel <= SPP_RST;
            cfg_reg.trigger_mode      <= TRIG_RST;
            cfg_reg.vertical_zoom     <= ZOOM_RST;
            cfg_reg.display_width     <= WIDTH_RST;
            cfg_reg.display_height    <= HEIGHT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/smmt_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smmt_store
// Min and max column ring memories, one write port, registered reads.
// ----------------------------------------------------------------------------
module smmt_store #(
    parameter int BUFFER_DEPTH = smmt_pkg::BUFFER_DEPTH_DEF,
    parameter int SAMPLE_BITS  = smmt_pkg::SAMPLE_BITS_DEF,
    localparam int AW          = $clog2(BUFFER_DEPTH)
) (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [AW-1:0]          wr_addr,
    input  logic [SAMPLE_BITS-1:0] wr_min,
    input  logic [SAMPLE_BITS-1:0] wr_max,
    input  logic [AW-1:0]          rd_min_addr,
    input  logic [AW-1:0]          rd_max_addr,
    output logic [SAMPLE_BITS-1:0] rd_min,
    output logic [SAMPLE_BITS-1:0] rd_max
);
    import smmt_pkg::*;

    logic [SAMPLE_BITS-1:0] min_mem [BUFFER_DEPTH];
    logic [SAMPLE_BITS-1:0] max_mem [BUFFER_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            min_mem[wr_addr] <= wr_min;
        end
        rd_min <= min_mem[rd_min_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            max_mem[wr_addr] <= wr_max;
        end
        rd_max <= max_mem[rd_max_addr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/smmt_mult.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smmt_mult
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module smmt_mult #(
    parameter int A_W = smmt_pkg::SAMPLE_BITS_DEF + 17,
    parameter int B_W = smmt_pkg::OPB_W
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [A_W-1:0]   a,
    input  logic signed [B_W-1:0]   b,
    output logic signed [A_W+B_W-1:0] p
);
    import smmt_pkg::*;

    logic signed [A_W+B_W-1:0] p_reg;

    assign p = p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= a * b;
        end
    end

endmodule
`default_nettype wire

// ===== test/scope_minmax_trigger_columns_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scope_minmax_trigger_columns_tb
// Self-checking bench for the min/max scope column block. Sample streams,
// frame starts and column requests go in under random idling and output
// backpressure. Register settings span the extremes. Every frame report and
// column beat is compared field by field with a predictor of the min/max
// ring, the trigger search and the zoomed row mapping.
// ----------------------------------------------------------------------------
import smmt_pkg::*;

localparam int         RING_DEPTH      = BUFFER_DEPTH_DEF;
localparam int         SW              = SAMPLE_BITS_DEF;
localparam logic [1:0] CMD_UNUSED      = 2'd3;
localparam logic [1:0] TRIG_AS_FALLING = 2'd3;

typedef struct {
    logic                kind;
    logic                found;
    logic [INDEX_W-1:0]  start;
    logic [INDEX_W-1:0]  column;
    logic [HEIGHT_W-1:0] top;
    logic [HEIGHT_W-1:0] bottom;
    logic [1:0]          fill;
    logic                last;
} column_beat_t;

class column_scoreboard;
    logic signed [SW-1:0] low_ring [RING_DEPTH];
    logic signed [SW-1:0] high_ring [RING_DEPTH];
    logic signed [SW-1:0] run_low;
    logic signed [SW-1:0] run_high;
    int                   samples_left;
    int                   write_idx;
    int                   read_idx;
    int                   columns_done;
    int                   spp;
    logic [1:0]           trig;
    int                   zoom;
    int                   width;
    int                   height;
    column_beat_t         awaited [$];
    int                   mismatches;
    int                   beats_checked;
    int                   frames_seen;
    int                   columns_seen;

    function new();
        foreach (low_ring[i])
        begin
            low_ring[i]  = '0;
            high_ring[i] = '0;
        end
        spp          = int'(SPP_RST);
        trig         = TRIG_RST;
        zoom         = int'(ZOOM_RST);
        width        = int'(WIDTH_RST);
        height       = int'(HEIGHT_RST);
        run_low      = {1'b0, {(SW-1){1'b1}}};
        run_high     = {1'b1, {(SW-1){1'b0}}};
        samples_left = spp;
        write_idx    = 0;
        read_idx     = 0;
        columns_done = width;
        mismatches    = 0;
        beats_checked = 0;
        frames_seen   = 0;
        columns_seen  = 0;
    endfunction

    function void report(string what);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] mismatch: %s", $time, what);
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    function void load_register(logic [2:0] idx, logic [PDATA_W-1:0] value);
        case (idx)
            REG_SPP:    spp    = int'(value[SPP_W-1:0]);
            REG_TRIG:   trig   = value[1:0];
            REG_ZOOM:   zoom   = int'(value[ZOOM_W-1:0]);
            REG_WIDTH:  width  = int'(value[WIDTH_W-1:0]);
            REG_HEIGHT: height = int'(value[HEIGHT_W-1:0]);
            default: ;
        endcase
    endfunction

    function int frame_width();
        return (width > RING_DEPTH) ? RING_DEPTH : width;
    endfunction

    // row = floor(h * (2^(SW+7) - zoom * v) / 2^(SW+8)), clamped to 0..h
    function int map_row(logic signed [SW-1:0] v, output bit above);
        longint num;
        longint q;
        num   = longint'(height) * ((longint'(1) <<< (SW + 7)) - longint'(zoom) * longint'(v));
        above = num < longint'(height) * (longint'(1) <<< (SW + 7));
        q     = num >>> (SW + 8);
        if (q < 0)
            q = 0;
        if (q > height)
            q = height;
        return int'(q);
    endfunction

    function void note_input(logic [1:0] cmd, logic signed [SW-1:0] s);
        column_beat_t e;
        int           w;
        int           pos;
        int           prev;
        int           k;
        bit           hit;
        bit           top_up;
        bit           bot_up;
        e = '{default: '0};
        case (cmd)
            CMD_SAMPLE:
            begin
                if (s < run_low)
                    run_low = s;
                if (s > run_high)
                    run_high = s;
                if (samples_left <= 1)
                begin
                    low_ring[write_idx]  = run_low;
                    high_ring[write_idx] = run_high;
                    run_low      = {1'b0, {(SW-1){1'b1}}};
                    run_high     = {1'b1, {(SW-1){1'b0}}};
                    write_idx    = (write_idx + 1) % RING_DEPTH;
                    samples_left = (spp == 0) ? 1 : spp;
                end
                else
                    samples_left--;
            end
            CMD_FRAME:
            begin
                w       = frame_width();
                pos     = (write_idx + RING_DEPTH - w) % RING_DEPTH;
                e.kind  = KIND_FRAME;
                e.start = INDEX_W'(pos);
                k       = 0;
                while (trig != TRIG_OFF && k < RING_DEPTH && !e.found)
                begin
                    prev = (pos + RING_DEPTH - 1) % RING_DEPTH;
                    if (trig == TRIG_RISING)
                        hit = low_ring[prev] <= 0 && high_ring[pos] > 0;
                    else
                        hit = low_ring[prev] > 0 && high_ring[pos] <= 0;
                    if (hit)
                    begin
                        e.found = 1'b1;
                        e.start = INDEX_W'(pos);
                    end
                    pos = prev;
                    k++;
                end
                read_idx     = int'(e.start);
                columns_done = 0;
                awaited.push_back(e);
            end
            CMD_COLUMN:
            begin
                w = frame_width();
                if (columns_done < w)
                begin
                    read_idx = (read_idx + 1) % RING_DEPTH;
                    e.kind   = KIND_COLUMN;
                    e.column = INDEX_W'(columns_done);
                    e.top    = HEIGHT_W'(map_row(high_ring[read_idx], top_up));
                    e.bottom = HEIGHT_W'(map_row(low_ring[read_idx], bot_up));
                    if (top_up && bot_up)
                        e.fill = FILL_TOP;
                    else if (!top_up && !bot_up)
                        e.fill = FILL_BOTTOM;
                    else
                        e.fill = FILL_NONE;
                    e.last = (columns_done + 1 == w);
                    columns_done++;
                    awaited.push_back(e);
                end
            end
            default: ;
        endcase
    endfunction

    function void compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report($sformatf("beat %0d %s: got %0d, expected %0d",
                             beats_checked, name, got, want));
    endfunction

    function void check_result(column_beat_t got);
        column_beat_t want;
        beats_checked++;
        if (awaited.size() == 0)
        begin
            report($sformatf("beat %0d arrived with nothing expected", beats_checked));
            return;
        end
        want = awaited.pop_front();
        compare_field("result_kind", got.kind, want.kind);
        compare_field("trigger_found", got.found, want.found);
        compare_field("start_index", got.start, want.start);
        compare_field("column_x", got.column, want.column);
        compare_field("top_row", got.top, want.top);
        compare_field("bottom_row", got.bottom, want.bottom);
        compare_field("fill_side", got.fill, want.fill);
        compare_field("last_column", got.last, want.last);
        if (want.kind == KIND_FRAME)
            frames_seen++;
        else
            columns_seen++;
    endfunction
endclass

module scope_minmax_trigger_columns_tb;

    localparam int CLK_HALF      = 5;
    localparam int STALL_LIMIT   = 12000;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 32;

    localparam int WAVE_ANY       = 0;
    localparam int WAVE_NEAR_ZERO = 1;
    localparam int WAVE_RAILS     = 2;
    localparam int WAVE_MIXED     = 3;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    smmt_in_if  sample_in_bus ();
    smmt_out_if column_out_bus ();

    column_scoreboard sb;
    logic             steady;
    int               hold_req;
    int               items_driven;
    int               settings_used;
    int               quiet_cycles = 0;

    scope_minmax_trigger_columns dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_in_bus),
        .column_out (column_out_bus),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    // result side: random stalls, plus a long hold-off on request
    initial
    begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        column_out_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                column_out_bus.ready <= 1'b0;
            end
            else
                column_out_bus.ready <= steady || ($urandom_range(0, 99) >= 16);
        end
    end

    always @(posedge clk)
    begin : beat_monitor
        column_beat_t got;
        if (rst_n)
        begin
            if (sample_in_bus.valid && sample_in_bus.ready)
                sb.note_input(sample_in_bus.command, sample_in_bus.sample_value);
            if (column_out_bus.valid && column_out_bus.ready)
            begin
                got.kind   = column_out_bus.result_kind;
                got.found  = column_out_bus.trigger_found;
                got.start  = column_out_bus.start_index;
                got.column = column_out_bus.column_x;
                got.top    = column_out_bus.top_row;
                got.bottom = column_out_bus.bottom_row;
                got.fill   = column_out_bus.fill_side;
                got.last   = column_out_bus.last_column;
                sb.check_result(got);
            end
            if ((sample_in_bus.valid && sample_in_bus.ready) ||
                (column_out_bus.valid && column_out_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= STALL_LIMIT);
        $display("no beat moved on either channel for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [SW-1:0] pick_sample(input int style);
        int k;
        k = (style == WAVE_MIXED) ? $urandom_range(WAVE_ANY, WAVE_RAILS) : style;
        case (k)
            WAVE_ANY:       return SW'($urandom());
            WAVE_NEAR_ZERO: return SW'($urandom_range(0, 16) - 8);
            default:
                case ($urandom_range(0, 4))
                    0:       return {1'b0, {(SW-1){1'b1}}};
                    1:       return {1'b1, {(SW-1){1'b0}}};
                    2:       return '0;
                    3:       return '1;
                    default: return SW'(1);
                endcase
        endcase
    endfunction

    task automatic push_item(input logic [1:0] cmd, input logic [SW-1:0] value);
        if (!steady && $urandom_range(0, 99) < 16)
        begin
            sample_in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        sample_in_bus.valid        <= 1'b1;
        sample_in_bus.command      <= cmd;
        sample_in_bus.sample_value <= value;
        do
            @(posedge clk);
        while (!sample_in_bus.ready);
        if (cmd != CMD_UNUSED)
            items_driven++;
    endtask

    task automatic wait_idle();
        sample_in_bus.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.load_register(idx, PDATA_W'(value));
    endtask

    task automatic configure(input int spp_v, input logic [1:0] trig_v, input int zoom_v,
                             input int width_v, input int height_v);
        wait_idle();
        write_register(REG_SPP, spp_v);
        write_register(REG_TRIG, int'(trig_v));
        write_register(REG_ZOOM, zoom_v);
        write_register(REG_WIDTH, width_v);
        write_register(REG_HEIGHT, height_v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // samples, then a frame start, then its column requests with some noise
    task automatic run_frame(input int n_samples, input int n_cols, input int style);
        int c;
        repeat (n_samples) push_item(CMD_SAMPLE, pick_sample(style));
        push_item(CMD_FRAME, SW'($urandom()));
        for (c = 0; c < n_cols; c++)
        begin
            if (!steady && $urandom_range(0, 99) < 6)
                push_item(($urandom_range(0, 1) != 0) ? CMD_UNUSED : CMD_SAMPLE,
                          SW'($urandom()));
            push_item(CMD_COLUMN, SW'($urandom()));
        end
    endtask

    initial
    begin : stimulus
        int   spp_v;
        int   zoom_v;
        int   width_v;
        int   height_v;
        int   n_cols;
        int   eff;
        logic [1:0] trig_v;
        sb            = new();
        steady        = 1'b0;
        hold_req      = 0;
        items_driven  = 0;
        settings_used = 0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        sample_in_bus.valid        = 1'b0;
        sample_in_bus.command      = CMD_SAMPLE;
        sample_in_bus.sample_value = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: rail samples, rising and falling hits, frame end, stray commands
        configure(1, TRIG_RISING, 256, 4, 512);
        push_item(CMD_COLUMN, '0);
        push_item(CMD_SAMPLE, 16'h8000);
        push_item(CMD_SAMPLE, 16'h7FFF);
        push_item(CMD_SAMPLE, 16'h0000);
        push_item(CMD_SAMPLE, 16'hFFFF);
        push_item(CMD_SAMPLE, 16'h0001);
        push_item(CMD_SAMPLE, 16'h7FFF);
        push_item(CMD_SAMPLE, 16'h8000);
        push_item(CMD_SAMPLE, 16'hFFFF);
        push_item(CMD_FRAME, 16'hFFFF);
        repeat (5) push_item(CMD_COLUMN, 16'h5555);
        push_item(CMD_UNUSED, 16'hAAAA);
        configure(1, TRIG_FALLING, 256, 3, 512);
        push_item(CMD_SAMPLE, 16'h0001);
        push_item(CMD_SAMPLE, 16'h0001);
        push_item(CMD_SAMPLE, 16'h8000);
        push_item(CMD_SAMPLE, 16'h0000);
        push_item(CMD_FRAME, '0);
        repeat (3) push_item(CMD_COLUMN, '0);

        // corner settings
        configure(0, TRIG_FALLING, 256, 6, 512);
        run_frame(20, 6, WAVE_MIXED);
        configure(3, TRIG_AS_FALLING, 65535, 8, 4096);
        run_frame(40, 9, WAVE_RAILS);
        configure(2, TRIG_OFF, 0, 5, 1);
        run_frame(16, 5, WAVE_ANY);
        configure(1, TRIG_RISING, 256, 0, 0);
        run_frame(10, 2, WAVE_NEAR_ZERO);
        configure(1, TRIG_FALLING, 300, 3, 0);
        run_frame(10, 3, WAVE_MIXED);
        configure(1, TRIG_RISING, 1, 1, 64);
        run_frame(6, 2, WAVE_NEAR_ZERO);
        configure(1024, TRIG_FALLING, 1, 2048, 4096);
        run_frame(40, 20, WAVE_ANY);

        // frame wider than the ring with no idling on either side
        steady <= 1'b1;
        configure(1, TRIG_RISING, 512, 4095, 100);
        run_frame(40, 300, WAVE_MIXED);
        wait_idle();
        steady <= 1'b0;

        // receiver holds off while column requests keep coming
        configure(1, TRIG_OFF, 256, 64, 256);
        hold_req <= hold_req + 1;
        run_frame(30, 64, WAVE_ANY);

        while (items_driven < RANDOM_ITEMS)
        begin
            spp_v  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
            trig_v = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0:       zoom_v = 256;
                1:       zoom_v = 65535;
                2:       zoom_v = $urandom_range(0, 65535);
                default: zoom_v = $urandom_range(0, 1024);
            endcase
            width_v = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 200)
                                                   : $urandom_range(1, 24);
            case ($urandom_range(0, 7))
                0:       height_v = 0;
                1:       height_v = 1;
                2:       height_v = 4096;
                default: height_v = $urandom_range(2, 4095);
            endcase
            configure(spp_v, trig_v, zoom_v, width_v, height_v);
            eff = (spp_v == 0) ? 1 : spp_v;
            repeat ($urandom_range(1, 3))
            begin
                case ($urandom_range(0, 5))
                    0:       n_cols = width_v + $urandom_range(1, 2);
                    1:       n_cols = width_v / 2;
                    default: n_cols = width_v;
                endcase
                run_frame(eff * $urandom_range(1, width_v + 8) + $urandom_range(0, 3),
                          n_cols, $urandom_range(WAVE_ANY, WAVE_MIXED));
            end
        end

        wait_idle();
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected beats never arrived", sb.pending()));
        $display("run covered %0d register settings, %0d frame reports, %0d column beats",
                 settings_used, sb.frames_seen, sb.columns_seen);
        $display("%0d beats checked, %0d mismatches", sb.beats_checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/smmt_pkg.sv
rtl/core/smmt_if.sv
rtl/core/smmt_cfg_regs.sv
rtl/core/smmt_store.sv
rtl/core/smmt_mult.sv
rtl/core/scope_minmax_trigger_columns.sv
test/scope_minmax_trigger_columns_tb.sv
